// File: design/f32dl_pkg.sv
// Package for the FAT32 directory lookup block: field widths, codes, register map
// and stream widths.
// No dependencies.
package f32dl_pkg;

    localparam int ADDR_W    = 44;
    localparam int CLUSTER_W = 28;
    localparam int INDEX_W   = 16;
    localparam int MUL_A_W   = 44;
    localparam int MUL_B_W   = 16;

    localparam int S_TDATA_W = 192;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 3;

    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;

    // Input modes carried on s_tuser
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_ENTRY = 2'd1;
    localparam logic [1:0] MODE_FAT   = 2'd2;

    // Register indexes (byte address 8*index)
    localparam logic [2:0] REG_BPS      = 3'd0;
    localparam logic [2:0] REG_SPC      = 3'd1;
    localparam logic [2:0] REG_RSV      = 3'd2;
    localparam logic [2:0] REG_COPIES   = 3'd3;
    localparam logic [2:0] REG_SPF      = 3'd4;
    localparam logic [2:0] REG_NAME_B   = 3'd5;
    localparam logic [2:0] REG_NAME_E   = 3'd6;

    // Register reset values
    localparam logic [12:0] BPS_RESET    = 13'd512;
    localparam logic [7:0]  SPC_RESET    = 8'd8;
    localparam logic [15:0] RSV_RESET    = 16'd32;
    localparam logic [7:0]  COPIES_RESET = 8'd2;
    localparam logic [31:0] SPF_RESET    = 32'd128;
    localparam logic [63:0] NAME_B_RESET = 64'h2020_2020_2020_2020;
    localparam logic [23:0] NAME_E_RESET = 24'h20_2020;

    // Directory entry and FAT markers
    localparam logic [7:0] MARK_FREE      = 8'h00;
    localparam logic [7:0] MARK_DELETED   = 8'hE5;
    localparam logic [7:0] MARK_BLANK     = 8'h20;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
    localparam logic [CLUSTER_W-1:0] BAD_CLUSTER  = 28'hFFF_FFF7;
    localparam logic [CLUSTER_W-1:0] END_OF_CHAIN = 28'hFFF_FFF8;
    localparam logic [INDEX_W-1:0]   MAX_ENTRIES  = 16'd32768;

    typedef enum logic [2:0] {
        VERDICT_READ_ENTRY = 3'd0,
        VERDICT_READ_FAT   = 3'd1,
        VERDICT_FOUND      = 3'd2,
        VERDICT_NOT_FOUND  = 3'd3,
        VERDICT_BLANK      = 3'd4,
        VERDICT_BAD_CLUST  = 3'd5,
        VERDICT_UNEXPECTED = 3'd6
    } verdict_t;

endpackage

// File: design/fat32_directory_lookup.sv
// Top level of the FAT32 directory lookup block: stream ports, APB registers,
// search state and a sequenced address unit built on one shared multiplier.
// Depends on f32dl_pkg.

// Searches one FAT32 directory for an 11-byte space-padded short name. A start word
// (s_tuser = 0) names the directory's first cluster; the block answers with the byte
// address of directory entry 0 (verdict 0) or of the cluster's FAT entry (verdict 1).
// The host reads that location and feeds it back as an entry word (s_tuser = 1) or a
// FAT word (s_tuser = 2), and each answer either ends the search (found, not found,
// blank name, bad cluster) or asks for the next read. Deleted and long-name entries
// are skipped; a zero first byte or the end of the cluster moves on to the FAT entry,
// and the chain is followed until its end mark. A word that does not fit the current
// state gets verdict 6 and leaves the search untouched. Timing: a word that ends the
// search or is unexpected gives its result in the cycle after acceptance. A word that
// leads to an entry or FAT read first passes a step that compares the entry index
// with the entry count (not taken when a zero first byte sends it straight to the FAT
// entry), then the single 44x16 multiplier, which is stepped through the address
// products (each term of the address) one product per cycle, and a final add into the
// result register; the entry count product (sector size times cluster size) is taken
// in the accepting cycle. s_tready is low while a word is being worked on and while a
// result waits on m_tready. The user must write registers through APB only while the
// block is idle; the block itself does not enforce it.
module fat32_directory_lookup
    import f32dl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata, lowest bit up: dir_cluster[27:0], entry_name_base[91:28],
    // entry_name_ext[115:92], entry_attr[123:116], entry_cluster_high[139:124],
    // entry_cluster_low[155:140], fat_word[187:156], zero fill[191:188]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: mode[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata, lowest bit up: read_address[43:0], found_cluster[71:44]
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: verdict[2:0]
    output logic [M_TUSER_W-1:0] m_tuser,
    // Configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_E_RSV,
        ST_E_SPF,
        ST_E_FATB,
        ST_E_CLUS,
        ST_E_CLUSB,
        ST_E_DONE,
        ST_F_RSV,
        ST_F_DONE
    } state_t;

    // ---------------------------------------------------------------------
    // Input field unpacking
    // ---------------------------------------------------------------------
    logic [CLUSTER_W-1:0] in_dir_cluster;
    logic [63:0]          in_name_base;
    logic [23:0]          in_name_ext;
    logic [7:0]           in_attr;
    logic [15:0]          in_cl_high;
    logic [15:0]          in_cl_low;
    logic [31:0]          in_fat_word;
    logic [1:0]           in_mode;

    assign in_dir_cluster   = s_tdata[27:0];
    assign in_name_base     = s_tdata[91:28];
    assign in_name_ext      = s_tdata[115:92];
    assign in_attr          = s_tdata[123:116];
    assign in_cl_high       = s_tdata[139:124];
    assign in_cl_low        = s_tdata[155:140];
    assign in_fat_word      = s_tdata[187:156];
    assign in_mode          = s_tuser;

    // ---------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------
    state_t               state_reg, state_next;
    logic                 searching_reg, searching_next;
    logic                 awaiting_fat_reg, awaiting_fat_next;
    logic [CLUSTER_W-1:0] cluster_reg, cluster_next;
    logic [INDEX_W-1:0]   index_reg, index_next;
    logic [MUL_A_W-1:0]   prod_reg, prod_next;
    logic [ADDR_W-1:0]    acc_reg, acc_next;
    logic                 m_valid_reg, m_valid_next;
    verdict_t             verdict_reg, verdict_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [CLUSTER_W-1:0] found_reg, found_next;

    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] rsv_reg;
    logic [7:0]  copies_reg;
    logic [31:0] spf_reg;
    logic [63:0] name_b_reg;
    logic [23:0] name_e_reg;

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    logic       s_accept;
    logic       cfg_write;
    logic [2:0] cfg_index;

    assign s_tready  = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[5:3];

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = verdict_reg;
    assign m_tdata  = {found_reg, addr_reg};

    // Register read-back
    always_comb begin
        prdata = '0;
        unique case (cfg_index)
            REG_BPS:    prdata = {51'd0, bps_reg};
            REG_SPC:    prdata = {56'd0, spc_reg};
            REG_RSV:    prdata = {48'd0, rsv_reg};
            REG_COPIES: prdata = {56'd0, copies_reg};
            REG_SPF:    prdata = {32'd0, spf_reg};
            REG_NAME_B: prdata = name_b_reg;
            REG_NAME_E: prdata = {40'd0, name_e_reg};
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Shared multiplier: operands picked by the sequencer step, low 44 bits kept
    // ---------------------------------------------------------------------
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_A_W+MUL_B_W-1:0] mul_full;
    logic [MUL_A_W-1:0]         mul_p;
    logic [MUL_A_W-1:0]         cluster_off;

    // Cluster numbering starts at 2; wrap below that like the address does
    assign cluster_off = {{(MUL_A_W-CLUSTER_W){1'b0}}, cluster_reg} - MUL_A_W'(2);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_IDLE: begin
                mul_a = MUL_A_W'(bps_reg);
                mul_b = MUL_B_W'(spc_reg);
            end
            ST_E_RSV, ST_F_RSV: begin
                mul_a = MUL_A_W'(rsv_reg);
                mul_b = MUL_B_W'(bps_reg);
            end
            ST_E_SPF: begin
                mul_a = MUL_A_W'(spf_reg);
                mul_b = MUL_B_W'(copies_reg);
            end
            ST_E_FATB, ST_E_CLUSB: begin
                mul_a = prod_reg;
                mul_b = MUL_B_W'(bps_reg);
            end
            ST_E_CLUS: begin
                mul_a = cluster_off;
                mul_b = MUL_B_W'(spc_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign mul_p    = mul_full[MUL_A_W-1:0];

    // ---------------------------------------------------------------------
    // Entry checks on the incoming word
    // ---------------------------------------------------------------------
    logic [7:0]           first_byte;
    logic                 name_match;
    logic                 entry_skip;
    logic [CLUSTER_W-1:0] fat_next;
    logic [15:0]          n_raw;
    logic [INDEX_W-1:0]   n_cap;

    assign first_byte = in_name_base[63:56];
    assign name_match = (in_name_base == name_b_reg) && (in_name_ext == name_e_reg);
    assign entry_skip = (first_byte == MARK_DELETED) || (in_attr == ATTR_LONG_NAME);
    assign fat_next   = in_fat_word[CLUSTER_W-1:0];

    // Entries per cluster: bps*spc/32, capped
    assign n_raw = prod_reg[20:5];
    assign n_cap = (n_raw > MAX_ENTRIES) ? MAX_ENTRIES : n_raw;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        state_next        = state_reg;
        searching_next    = searching_reg;
        awaiting_fat_next = awaiting_fat_reg;
        cluster_next      = cluster_reg;
        index_next        = index_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        m_valid_next      = m_valid_reg && !m_tready;
        verdict_next      = verdict_reg;
        addr_next         = addr_reg;
        found_next        = found_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    // Entry count product is ready for ST_DECIDE
                    prod_next    = mul_p;
                    m_valid_next = 1'b0;
                    addr_next    = '0;
                    found_next   = '0;
                    if (in_mode == MODE_START) begin
                        searching_next = 1'b1;
                        cluster_next   = in_dir_cluster;
                        index_next     = '0;
                        state_next     = ST_DECIDE;
                    end else if (in_mode == MODE_ENTRY && searching_reg
                                 && !awaiting_fat_reg) begin
                        if (first_byte == MARK_FREE) begin
                            // end of directory marker: go to the FAT entry
                            awaiting_fat_next = 1'b1;
                            state_next        = ST_F_RSV;
                        end else if (!entry_skip && first_byte == MARK_BLANK) begin
                            searching_next = 1'b0;
                            m_valid_next   = 1'b1;
                            verdict_next   = VERDICT_BLANK;
                        end else if (!entry_skip && name_match) begin
                            searching_next = 1'b0;
                            m_valid_next   = 1'b1;
                            verdict_next   = VERDICT_FOUND;
                            found_next     = {in_cl_high[11:0], in_cl_low};
                        end else begin
                            index_next = index_reg + INDEX_W'(1);
                            state_next = ST_DECIDE;
                        end
                    end else if (in_mode == MODE_FAT && searching_reg
                                 && awaiting_fat_reg) begin
                        awaiting_fat_next = 1'b0;
                        if (fat_next == BAD_CLUSTER) begin
                            searching_next = 1'b0;
                            m_valid_next   = 1'b1;
                            verdict_next   = VERDICT_BAD_CLUST;
                        end else if (fat_next >= END_OF_CHAIN) begin
                            searching_next = 1'b0;
                            m_valid_next   = 1'b1;
                            verdict_next   = VERDICT_NOT_FOUND;
                        end else begin
                            cluster_next = fat_next;
                            index_next   = '0;
                            state_next   = ST_DECIDE;
                        end
                    end else begin
                        // out of turn: report and leave the search alone
                        m_valid_next = 1'b1;
                        verdict_next = VERDICT_UNEXPECTED;
                    end
                end
            end

            ST_DECIDE: begin
                if (index_reg >= n_cap) begin
                    awaiting_fat_next = 1'b1;
                    state_next        = ST_F_RSV;
                end else begin
                    awaiting_fat_next = 1'b0;
                    state_next        = ST_E_RSV;
                end
            end

            // Entry address: rsv*bps + copies*spf*bps + (cluster-2)*spc*bps + index*32
            ST_E_RSV: begin
                prod_next  = mul_p;
                acc_next   = {{(ADDR_W-INDEX_W-5){1'b0}}, index_reg, 5'd0};
                state_next = ST_E_SPF;
            end
            ST_E_SPF: begin
                acc_next   = acc_reg + prod_reg;
                prod_next  = mul_p;
                state_next = ST_E_FATB;
            end
            ST_E_FATB: begin
                prod_next  = mul_p;
                state_next = ST_E_CLUS;
            end
            ST_E_CLUS: begin
                acc_next   = acc_reg + prod_reg;
                prod_next  = mul_p;
                state_next = ST_E_CLUSB;
            end
            ST_E_CLUSB: begin
                prod_next  = mul_p;
                state_next = ST_E_DONE;
            end
            ST_E_DONE: begin
                m_valid_next = 1'b1;
                verdict_next = VERDICT_READ_ENTRY;
                addr_next    = acc_reg + prod_reg;
                state_next   = ST_IDLE;
            end

            // FAT address: rsv*bps + 4*cluster, first FAT copy
            ST_F_RSV: begin
                prod_next  = mul_p;
                acc_next   = {{(ADDR_W-CLUSTER_W-2){1'b0}}, cluster_reg, 2'd0};
                state_next = ST_F_DONE;
            end
            ST_F_DONE: begin
                m_valid_next = 1'b1;
                verdict_next = VERDICT_READ_FAT;
                addr_next    = acc_reg + prod_reg;
                state_next   = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            searching_reg    <= 1'b0;
            awaiting_fat_reg <= 1'b0;
            cluster_reg      <= '0;
            index_reg        <= '0;
            m_valid_reg      <= 1'b0;
            bps_reg          <= BPS_RESET;
            spc_reg          <= SPC_RESET;
            rsv_reg          <= RSV_RESET;
            copies_reg       <= COPIES_RESET;
            spf_reg          <= SPF_RESET;
            name_b_reg       <= NAME_B_RESET;
            name_e_reg       <= NAME_E_RESET;
        end else begin
            state_reg        <= state_next;
            searching_reg    <= searching_next;
            awaiting_fat_reg <= awaiting_fat_next;
            cluster_reg      <= cluster_next;
            index_reg        <= index_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_BPS:    bps_reg    <= pwdata[12:0];
                    REG_SPC:    spc_reg    <= pwdata[7:0];
                    REG_RSV:    rsv_reg    <= pwdata[15:0];
                    REG_COPIES: copies_reg <= pwdata[7:0];
                    REG_SPF:    spf_reg    <= pwdata[31:0];
                    REG_NAME_B: name_b_reg <= pwdata;
                    REG_NAME_E: name_e_reg <= pwdata[23:0];
                    default:    ;
                endcase
            end
        end
        // Datapath and result payload: no reset
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        verdict_reg <= verdict_next;
        addr_reg    <= addr_next;
        found_reg   <= found_next;
    end

endmodule

// File: test/testbench.sv
// Testbench for fat32_directory_lookup: acts as the host of a directory search, predicts
// each result word and checks it on the result stream; settings go in over APB.
// Depends on f32dl_pkg and the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import f32dl_pkg::*;

    // Mode 3 has no meaning and must be answered as unexpected
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 245;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 32;
    localparam int REPORT_LIMIT    = 10;

    // One input word, fields as they sit on s_tdata and s_tuser
    typedef struct packed {
        logic [1:0]  mode;
        logic [27:0] dir_cluster;
        logic [63:0] name_base;
        logic [23:0] name_ext;
        logic [7:0]  attr;
        logic [15:0] cluster_high;
        logic [15:0] cluster_low;
        logic [31:0] fat_word;
    } dir_word_t;

    typedef struct packed {
        verdict_t             verdict;
        logic [ADDR_W-1:0]    read_address;
        logic [CLUSTER_W-1:0] found_cluster;
    } lookup_result_t;

    // Shadow of the search logic plus the queue of result words still to come
    class lookup_scoreboard;
        logic [12:0] cfg_bps;
        logic [7:0]  cfg_spc;
        logic [15:0] cfg_rsv;
        logic [7:0]  cfg_copies;
        logic [31:0] cfg_spf;
        logic [63:0] target_base;
        logic [23:0] target_ext;

        bit          searching;
        logic [27:0] scan_cluster;
        logic [15:0] entry_idx;
        bit          awaiting_fat;

        lookup_result_t awaited[$];
        int mismatches;

        function new();
            cfg_bps      = BPS_RESET;
            cfg_spc      = SPC_RESET;
            cfg_rsv      = RSV_RESET;
            cfg_copies   = COPIES_RESET;
            cfg_spf      = SPF_RESET;
            target_base  = NAME_B_RESET;
            target_ext   = NAME_E_RESET;
            searching    = 1'b0;
            scan_cluster = '0;
            entry_idx    = '0;
            awaiting_fat = 1'b0;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_BPS:    cfg_bps     = value[12:0];
                REG_SPC:    cfg_spc     = value[7:0];
                REG_RSV:    cfg_rsv     = value[15:0];
                REG_COPIES: cfg_copies  = value[7:0];
                REG_SPF:    cfg_spf     = value[31:0];
                REG_NAME_B: target_base = value;
                REG_NAME_E: target_ext  = value[23:0];
                default: ;
            endcase
        endfunction

        function lookup_result_t bare_result(verdict_t v);
            lookup_result_t r;
            r.verdict       = v;
            r.read_address  = '0;
            r.found_cluster = '0;
            return r;
        endfunction

        // FAT entry of the current cluster, first FAT copy
        function lookup_result_t ask_fat();
            lookup_result_t r;
            logic [63:0] a;
            a = 64'(cfg_rsv) * 64'(cfg_bps) + 64'(scan_cluster) * 64'd4;
            awaiting_fat   = 1'b1;
            r              = bare_result(VERDICT_READ_FAT);
            r.read_address = a[ADDR_W-1:0];
            return r;
        endfunction

        // Next directory entry, or the FAT entry once the cluster is used up
        function lookup_result_t ask_entry();
            lookup_result_t r;
            logic [63:0] n;
            logic [63:0] a;
            n = (64'(cfg_bps) * 64'(cfg_spc)) >> 5;
            if (n > 64'(MAX_ENTRIES)) n = 64'(MAX_ENTRIES);
            if (64'(entry_idx) >= n) return ask_fat();
            awaiting_fat = 1'b0;
            a = 64'(cfg_rsv) * 64'(cfg_bps)
              + 64'(cfg_copies) * 64'(cfg_spf) * 64'(cfg_bps)
              + (64'(scan_cluster) - 64'd2) * 64'(cfg_spc) * 64'(cfg_bps)
              + 64'(entry_idx) * 64'd32;
            r              = bare_result(VERDICT_READ_ENTRY);
            r.read_address = a[ADDR_W-1:0];
            return r;
        endfunction

        function void note_word(dir_word_t w);
            lookup_result_t r;
            logic [7:0]  lead;
            logic [27:0] link;
            logic [31:0] joined;
            bit          judged;
            lead   = w.name_base[63:56];
            link   = w.fat_word[27:0];
            joined = {w.cluster_high, w.cluster_low};
            judged = (lead != MARK_DELETED) && (w.attr != ATTR_LONG_NAME);
            r = bare_result(VERDICT_UNEXPECTED);
            if (w.mode == MODE_START) begin
                searching    = 1'b1;
                scan_cluster = w.dir_cluster;
                entry_idx    = '0;
                r = ask_entry();
            end else if (w.mode == MODE_ENTRY && searching && !awaiting_fat) begin
                if (lead == MARK_FREE) begin
                    r = ask_fat();
                end else if (judged && lead == MARK_BLANK) begin
                    searching = 1'b0;
                    r = bare_result(VERDICT_BLANK);
                end else if (judged && w.name_base == target_base
                             && w.name_ext == target_ext) begin
                    searching = 1'b0;
                    r = bare_result(VERDICT_FOUND);
                    r.found_cluster = joined[27:0];
                end else begin
                    entry_idx = entry_idx + 16'd1;
                    r = ask_entry();
                end
            end else if (w.mode == MODE_FAT && searching && awaiting_fat) begin
                awaiting_fat = 1'b0;
                if (link == BAD_CLUSTER) begin
                    searching = 1'b0;
                    r = bare_result(VERDICT_BAD_CLUST);
                end else if (link >= END_OF_CHAIN) begin
                    searching = 1'b0;
                    r = bare_result(VERDICT_NOT_FOUND);
                end else begin
                    scan_cluster = link;
                    entry_idx    = '0;
                    r = ask_entry();
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_result(logic [2:0] v, logic [M_TDATA_W-1:0] data);
            lookup_result_t e;
            logic [ADDR_W-1:0]    addr;
            logic [CLUSTER_W-1:0] cl;
            addr = data[ADDR_W-1:0];
            cl   = data[ADDR_W+CLUSTER_W-1:ADDR_W];
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result word with none pending: verdict %0d address %h cluster %h",
                             v, addr, cl);
                return;
            end
            e = awaited.pop_front();
            if (v !== e.verdict || addr !== e.read_address || cl !== e.found_cluster) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: wanted verdict %0d address %h cluster %h, %s %0d %h %h",
                             e.verdict, e.read_address, e.found_cluster, "got", v, addr, cl);
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Shared knobs: no_idle keeps both sides busy, hold_request starts a long sink stall
    bit no_idle      = 1'b0;
    bit hold_request = 1'b0;

    lookup_scoreboard sb = new();

    fat32_directory_lookup dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one word, maybe after a short gap, and hold it until the block takes it.
    // Valid stays high between back-to-back words so it is never dropped and raised
    // in the same step.
    task automatic send_word(input dir_word_t w);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 18) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.mode;
        s_tdata  <= {4'b0, w.fat_word, w.cluster_low, w.cluster_high, w.attr,
                     w.name_ext, w.name_base, w.dir_cluster};
        do @(posedge aclk); while (!s_tready);
        sb.note_word(w);
    endtask

    task automatic send_fields(input logic [1:0] mode, input logic [27:0] start,
                               input logic [63:0] base, input logic [23:0] ext,
                               input logic [7:0] attr, input logic [15:0] hi,
                               input logic [15:0] lo, input logic [31:0] fat);
        dir_word_t w;
        w = '{mode, start, base, ext, attr, hi, lo, fat};
        send_word(w);
    endtask

    // Drop valid and wait until every pending result word has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge
    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    // Set random bits above the register width; the block must drop them
    function automatic logic [63:0] with_junk(input logic [63:0] value, input int width,
                                              input bit enable);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        if (enable && $urandom_range(3) == 0) return value | (junk << width);
        return value;
    endfunction

    // Phase 0 takes the smallest legal volume, phase 1 the largest, the rest are random
    // and lean toward small clusters so cluster ends and chains come up often.
    task automatic load_settings(input int phase);
        logic [12:0] bps;
        logic [7:0]  spc;
        logic [15:0] rsv;
        logic [7:0]  copies;
        logic [31:0] spf;
        logic [63:0] tname;
        logic [23:0] tail;
        logic [87:0] padded;
        bit          junk;
        junk = (phase >= 4);
        if (phase == 0) begin
            bps = 13'd512; spc = 8'd1; rsv = 16'd1; copies = 8'd1; spf = 32'd1;
            tname = '0; tail = '0;
        end else if (phase == 1) begin
            bps = 13'd4096; spc = 8'd128; rsv = '1; copies = '1; spf = '1;
            tname = '1; tail = '1;
        end else begin
            case ($urandom_range(9))
                6:       bps = 13'd1024;
                7:       bps = 13'd2048;
                8:       bps = 13'd4096;
                9:       bps = 13'($urandom_range(512, 4096));
                default: bps = 13'd512;
            endcase
            spc    = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 128))
                                              : 8'($urandom_range(1, 2));
            rsv    = 16'($urandom_range(1, 65535));
            copies = 8'($urandom_range(1, 255));
            spf    = $urandom;
            if (spf == '0) spf = 32'd1;
            tname  = {$urandom, $urandom};
            tail   = 24'($urandom);
            if ($urandom_range(1) == 1) begin
                // letters padded with spaces, as a real short name looks
                for (int k = 0; k < 11; k++)
                    padded[8*k +: 8] = ($urandom_range(3) == 0) ? MARK_BLANK
                                                                : 8'(8'h41 + $urandom_range(25));
                tname = padded[87:24];
                tail  = padded[23:0];
            end
        end
        apb_write(REG_BPS,    with_junk(64'(bps), 13, junk));
        apb_write(REG_SPC,    with_junk(64'(spc), 8, junk));
        apb_write(REG_RSV,    with_junk(64'(rsv), 16, junk));
        apb_write(REG_COPIES, with_junk(64'(copies), 8, junk));
        apb_write(REG_SPF,    with_junk(64'(spf), 32, junk));
        apb_write(REG_NAME_B, tname);
        apb_write(REG_NAME_E, with_junk(64'(tail), 24, junk));
    endtask

    // Build the next host word from the predicted search state: mostly the answer the
    // block is waiting for, with random content, and about one word in ten pure noise.
    function automatic dir_word_t host_word();
        dir_word_t w;
        int pick;
        w.mode          = MODE_START;
        w.dir_cluster   = 28'($urandom);
        w.name_base     = {$urandom, $urandom};
        w.name_ext      = 24'($urandom);
        w.attr          = 8'($urandom);
        w.cluster_high  = 16'($urandom);
        w.cluster_low   = 16'($urandom);
        w.fat_word      = $urandom;
        if ($urandom_range(99) < 10) begin
            w.mode = 2'($urandom_range(3));
            return w;
        end
        pick = $urandom_range(99);
        if (!sb.searching) begin
            if (pick < 70)      w.dir_cluster = 28'($urandom_range(2, 200));
            else if (pick < 80) w.dir_cluster = 28'($urandom_range(1));
        end else if (!sb.awaiting_fat) begin
            w.mode = MODE_ENTRY;
            if (pick < 5) begin
                w.name_base[63:56] = MARK_FREE;
            end else if (pick < 20) begin
                w.name_base[63:56] = MARK_DELETED;
            end else if (pick < 28) begin
                // target name hidden behind the long-name attribute: skip it
                w.name_base = sb.target_base;
                w.name_ext  = sb.target_ext;
                w.attr      = ATTR_LONG_NAME;
            end else if (pick < 31) begin
                w.name_base[63:56] = MARK_BLANK;
            end else if (pick < 36) begin
                w.name_base = sb.target_base;
                w.name_ext  = sb.target_ext;
                if (w.attr == ATTR_LONG_NAME) w.attr = '0;
            end else if (pick < 40) begin
                w.attr = ATTR_LONG_NAME;
            end
        end else begin
            w.mode = MODE_FAT;
            if (pick < 10)      w.fat_word[27:0] = BAD_CLUSTER;
            else if (pick < 25) w.fat_word[27:0] = END_OF_CHAIN | 28'($urandom_range(7));
            else if (pick < 35) w.fat_word[27:0] = 28'($urandom_range(1));
            else if (pick < 80) w.fat_word[27:0] = 28'($urandom_range(2, 200));
        end
        return w;
    endfunction

    // Result side: check each accepted word, then pick m_tready for the next cycle.
    // A hold request stalls the sink for a long stretch while the sender keeps offering.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 18);
            end
        end
    end

    // Give up if the run hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        int phase;
        int n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: words out of place, skips, free entry, chain step, blank name,
        // largest cluster number, bad cluster mark, restart while busy, end of chain.
        send_fields(MODE_ENTRY, '0, '0, '0, '0, '0, '0, '0);
        send_fields(MODE_FAT, '0, '0, '0, '0, '0, '0, '1);
        send_fields(MODE_UNUSED, '1, '1, '1, '1, '1, '1, '1);
        send_fields(MODE_START, 28'd2, '0, '0, '0, '0, '0, '0);
        send_fields(MODE_FAT, '0, '0, '0, '0, '0, '0, '0);
        send_fields(MODE_ENTRY, '0, {MARK_DELETED, 56'h4142_4344_4546_47}, 24'h545854,
                    8'h20, '0, '0, '0);
        send_fields(MODE_ENTRY, '0, NAME_B_RESET, NAME_E_RESET, ATTR_LONG_NAME, '0, '0, '0);
        send_fields(MODE_ENTRY, '0, '1, '1, '1, '1, '1, '0);
        send_fields(MODE_ENTRY, '0, {MARK_FREE, 56'hFF_FFFF_FFFF_FFFF}, '1, '1, '1, '1, '1);
        send_fields(MODE_ENTRY, '0, '0, '0, '0, '0, '0, '0);
        send_fields(MODE_FAT, '0, '0, '0, '0, '0, '0, 32'hF000_0003);
        send_fields(MODE_ENTRY, '0, {MARK_BLANK, 56'h4142_4344_4546_47}, '0, '0, '0, '0, '0);
        send_fields(MODE_START, 28'hFFF_FFFF, '0, '0, '0, '0, '0, '0);
        send_fields(MODE_ENTRY, '0, '0, '0, '0, '0, '0, '0);
        send_fields(MODE_FAT, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFF7);
        send_fields(MODE_START, 28'd0, '0, '0, '0, '0, '0, '0);
        send_fields(MODE_START, 28'd1, '0, '0, '0, '0, '0, '0);
        send_fields(MODE_ENTRY, '0, '0, '0, '0, '0, '0, '0);
        send_fields(MODE_FAT, '0, '0, '0, '0, '0, '0, 32'h0FFF_FFF8);
        drain();

        // One entry per cluster: pass over it to reach the cluster end, follow the chain
        // to cluster 0, then match the target with every cluster bit set.
        apb_write(REG_BPS, 64'd32);
        apb_write(REG_SPC, 64'd1);
        apb_write(REG_NAME_B, 64'h464F_4F20_2020_2020);
        apb_write(REG_NAME_E, 64'h54_5854);
        send_fields(MODE_START, 28'd9, '0, '0, '0, '0, '0, '0);
        send_fields(MODE_ENTRY, '0, 64'h4241_5220_2020_2020, 24'h545854, 8'h20, '0, '0, '0);
        send_fields(MODE_FAT, '0, '0, '0, '0, '0, '0, 32'd0);
        send_fields(MODE_ENTRY, '0, 64'h464F_4F20_2020_2020, 24'h545854, 8'h20,
                    '1, '1, '0);
        drain();

        // Clusters too small to hold an entry: go straight to the FAT every time
        apb_write(REG_BPS, 64'd16);
        send_fields(MODE_START, 28'd4, '0, '0, '0, '0, '0, '0);
        send_fields(MODE_FAT, '0, '0, '0, '0, '0, '0, 32'd1);
        send_fields(MODE_FAT, '0, '0, '0, '0, '0, '0, '1);
        drain();

        // Random phases; phase 2 stalls the sink for a long stretch, phase 3 never idles
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_settings(phase);
            no_idle = (phase == 3);
            if (phase == 2) hold_request = 1'b1;
            for (n = 0; n < WORDS_PER_PHASE; n++) send_word(host_word());
            drain();
        end
        no_idle = 1'b0;

        if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
